// ===== sv/base64_line_wrapped_encoder_macros.svh =====
// Assertion macros shared by the base64 line-wrapped encoder RTL.
// Included by the modules that carry concurrent checks; no dependencies.
`ifndef BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH
`define BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define B64LW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define B64LW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/b64lw_pkg.sv =====
// Package for the base64 line-wrapped encoder: block command type,
// character constants and the base64 alphabet lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64lw_pkg;

    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [6:0] BPL_RESET = 7'd16;
    localparam logic [6:0] CHAR_PAD  = 7'h3D;
    localparam logic [6:0] CHAR_NL   = 7'h0A;

    // Character slot that carries the newline of a block
    localparam logic [2:0] SLOT_NL   = 3'd4;
    localparam logic [2:0] SLOT_LAST = 3'd3;

    // One encoded block: left-aligned 24-bit group, byte count, newline flag
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  len;
        logic        nl;
    } cmd_t;

    // Map a 6-bit value to its base64 character
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] v7;
        logic [6:0] c;
        v7 = {1'b0, v};
        case (v) inside
            [6'd0:6'd25]:  c = v7 + 7'd65;
            [6'd26:6'd51]: c = v7 + 7'd71;
            [6'd52:6'd61]: c = v7 - 7'd4;
            6'd62:         c = 7'd43;
            default:       c = 7'd47;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64lw_front.sv =====
// Front end: gathers bytes into groups of up to three, tracks the line fill and
// issues one block command per group. Depends on b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_front
    import b64lw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [6:0] cfg_wr_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_final,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic       q_full,
    output      logic       q_push,
    output      cmd_t       q_cmd
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [6:0]  blk_reg, blk_next;
    logic [6:0]  bpl_reg;

    logic        accept;
    logic        close;
    logic [6:0]  blk_inc;
    logic        wrap;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign close    = (cnt_reg == 2'd2) || in_final;
    assign blk_inc  = blk_reg + 7'd1;
    assign wrap     = blk_inc >= bpl_reg;

    // Build the block command and the next group and line state
    always_comb begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        blk_next  = blk_reg;
        q_push    = 1'b0;
        q_cmd.len = cnt_reg + 2'd1;
        q_cmd.nl  = wrap || (in_final && (blk_inc != 7'd0));
        case (cnt_reg)
            2'd0:    q_cmd.word = {in_byte, 16'h0000};
            2'd1:    q_cmd.word = {held_reg[7:0], in_byte, 8'h00};
            default: q_cmd.word = {held_reg, in_byte};
        endcase
        if (accept) begin
            if (close) begin
                q_push    = 1'b1;
                held_next = 16'h0000;
                cnt_next  = 2'd0;
                blk_next  = (wrap || in_final) ? 7'd0 : blk_inc;
            end else begin
                held_next = {held_reg[7:0], in_byte};
                cnt_next  = cnt_reg + 2'd1;
            end
        end
    end

    // Hold group, line and configuration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 16'h0000;
            cnt_reg  <= 2'd0;
            blk_reg  <= 7'd0;
            bpl_reg  <= BPL_RESET;
        end else begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            blk_reg  <= blk_next;
            if (cfg_wr_en) begin
                bpl_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64lw_fifo.sv =====
// Short command queue between the front end and the character emitter.
// Depends on b64lw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_line_wrapped_encoder_macros.svh"

module b64lw_fifo
    import b64lw_pkg::*;
#(
    parameter int unsigned Depth = FIFO_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output      logic full,
    input  wire logic pop,
    output      cmd_t head_cmd,
    output      logic empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    cmd_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full     = count_reg == CntW'(Depth);
    assign empty    = count_reg == '0;
    assign head_cmd = mem_reg[rd_ptr_reg];

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `B64LW_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full, "push into full queue")
    `B64LW_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, !empty, "pop from empty queue")
    `B64LW_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CntW'(Depth), "count past depth")
    `B64LW_ASSERT_NEXT(a_push_lands, aclk, aresetn, push && !pop, !empty, "push lost")

endmodule

`default_nettype wire

// ===== sv/b64lw_back.sv =====
// Back end: turns each block command into four or five characters, one per
// cycle when not stalled, into an output register. Depends on b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_back
    import b64lw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cmd_t       head_cmd,
    input  wire logic       q_empty,
    output      logic       q_pop,
    output      logic [6:0] out_char,
    output      logic       out_last,
    output      logic       out_valid,
    input  wire logic       out_ready
);

    logic [2:0] slot_reg, slot_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       valid_reg, valid_next;

    logic       load;
    logic [5:0] sextet;
    logic [2:0] nsym;

    assign load = (!valid_reg || out_ready) && !q_empty;
    assign nsym = {1'b0, head_cmd.len} + 3'd1;

    // Pick the sextet of the current slot
    always_comb begin
        case (slot_reg)
            3'd0:    sextet = head_cmd.word[23:18];
            3'd1:    sextet = head_cmd.word[17:12];
            3'd2:    sextet = head_cmd.word[11:6];
            default: sextet = head_cmd.word[5:0];
        endcase
    end

    // Form the next character and advance the slot
    always_comb begin
        slot_next  = slot_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (slot_reg == SLOT_NL) begin
                char_next = CHAR_NL;
            end else if (slot_reg < nsym) begin
                char_next = b64_char(sextet);
            end else begin
                char_next = CHAR_PAD;
            end
            last_next = slot_reg == (head_cmd.nl ? SLOT_NL : SLOT_LAST);
            if (last_next) begin
                slot_next = 3'd0;
                q_pop     = 1'b1;
            end else begin
                slot_next = slot_reg + 3'd1;
            end
        end
    end

    // Hold slot counter and valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    // Hold output payload
    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ===== sv/base64_line_wrapped_encoder.sv =====
// Top level of the base64 line-wrapped encoder: front end, command queue
// and character emitter. Depends on b64lw_pkg and the three submodules.
//
//  Channel  Direction  tdata (low bit up)         tlast / other
//  s_axis   in         data_byte[7:0]             tlast = is_final
//  m_axis   out        out_char[6:0], zero bit 7  tlast = last_of_run
//  cfg      in         cfg_wr_data = blocks_per_line[6:0], cfg_wr_en
//
// A byte is taken while the command queue has room; a group of up to three
// bytes becomes a command that the emitter drains at one character per
// cycle when not stalled, four per block or five with a newline, through
// the single-character output register. Reset (synchronous, aresetn low)
// empties the queue and group state and loads 16 blocks per line. Output
// stalls back up through the queue to s_axis_tready; no clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module base64_line_wrapped_encoder
    import b64lw_pkg::*;
#(
    parameter int unsigned FifoDepth = FIFO_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data,    // blocks_per_line[6:0]
    input  wire logic       s_axis_tvalid,
    output      logic       s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  wire logic       s_axis_tlast,
    output      logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output      logic [7:0] m_axis_tdata,   // out_char[6:0], bit 7 zero
    output      logic       m_axis_tlast
);

    cmd_t       push_cmd;
    cmd_t       head_cmd;
    logic       q_push, q_pop, q_full, q_empty;
    logic [6:0] out_char;

    b64lw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_data (cfg_wr_data),
        .cfg_wr_en   (cfg_wr_en),
        .in_byte     (s_axis_tdata),
        .in_final    (s_axis_tlast),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    b64lw_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    b64lw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_char  (out_char),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

`default_nettype wire
